[design/tbrs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbrs_pkg
// Shared types, constants and helpers of the tape blank run splitter.
// ----------------------------------------------------------------------------
package tbrs_pkg;

	localparam int COUNT_BITS = 6;
	localparam logic [31:0] COUNT_MAX = 32'((64'd1 << COUNT_BITS) - 64'd1);

	localparam int REG_BITS = 6;
	localparam int SEG_BITS = 16;
	localparam int FRAME_BITS = 8;

	typedef enum logic [1:0] {
		MODE_FIVE  = 2'd0,
		MODE_SEVEN = 2'd1,
		MODE_EIGHT = 2'd2,
		MODE_SPARE = 2'd3
	} frame_mode_t;

	typedef enum logic [1:0] {
		REG_FRAME_MODE    = 2'd0,
		REG_SPLIT_LENGTH  = 2'd1,
		REG_LEADER_LENGTH = 2'd2,
		REG_TRAILER_LENGTH = 2'd3
	} reg_index_t;

	typedef enum logic {
		ACT_FRAME = 1'b0,
		ACT_END   = 1'b1
	} action_t;

	localparam logic [FRAME_BITS-1:0] MASK_FIVE  = 8'h1f;
	localparam logic [FRAME_BITS-1:0] MASK_SEVEN = 8'h7f;
	localparam logic [FRAME_BITS-1:0] MASK_EIGHT = 8'hff;

	localparam logic [1:0] RST_FRAME_MODE = 2'd2;
	localparam logic [REG_BITS-1:0] RST_SPLIT_LENGTH = 6'd50;
	localparam logic [REG_BITS-1:0] RST_LEADER_LENGTH = 6'd30;
	localparam logic [REG_BITS-1:0] RST_TRAILER_LENGTH = 6'd30;

	// one burst of results: zeros blank frames, then optionally one data frame
	typedef struct packed {
		logic                  load;
		logic [COUNT_BITS-1:0] zeros;
		logic                  has_frame;
		logic [FRAME_BITS-1:0] frame;
		logic [SEG_BITS-1:0]   seg;
		logic                  start;
	} burst_t;

	function automatic logic [COUNT_BITS-1:0] cap_count(input logic [REG_BITS-1:0] v);
		logic [31:0] w;
		w = {{(32-REG_BITS){1'b0}}, v};
		if (w > COUNT_MAX) begin
			return COUNT_MAX[COUNT_BITS-1:0];
		end
		return w[COUNT_BITS-1:0];
	endfunction

endpackage
`default_nettype wire

[design/tbrs_decode.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbrs_decode
// Configuration registers, segment state and per-request burst decode.
// ----------------------------------------------------------------------------
module tbrs_decode
	import tbrs_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [REG_BITS-1:0]   cfg_data,
	input  wire logic                  accept,
	input  wire logic                  action,
	input  wire logic [FRAME_BITS-1:0] frame_value,
	output burst_t                     burst
);

	logic [1:0]            frame_mode_q;
	logic [REG_BITS-1:0]   split_q;
	logic [REG_BITS-1:0]   leader_q;
	logic [REG_BITS-1:0]   trailer_q;
	logic                  in_seg_q;
	logic [COUNT_BITS-1:0] held_q;
	logic [SEG_BITS-1:0]   counter_q;

	logic                  in_seg_n;
	logic [COUNT_BITS-1:0] held_n;
	logic [SEG_BITS-1:0]   counter_n;
	logic [COUNT_BITS-1:0] held_inc;
	logic [COUNT_BITS-1:0] split_cap;
	logic [FRAME_BITS-1:0] mask;
	logic [FRAME_BITS-1:0] v;

	always_comb begin
		unique case (frame_mode_t'(frame_mode_q))
			MODE_FIVE:  mask = MASK_FIVE;
			MODE_SEVEN: mask = MASK_SEVEN;
			default:    mask = MASK_EIGHT;
		endcase
	end

	assign v = frame_value & mask;
	assign split_cap = cap_count((split_q == '0) ? REG_BITS'(1) : split_q);
	assign held_inc = held_q + COUNT_BITS'(1);

	always_comb begin
		burst = '0;
		burst.frame = v;
		burst.seg = counter_q;
		in_seg_n = in_seg_q;
		held_n = held_q;
		counter_n = counter_q;
		if (action_t'(action) == ACT_END) begin
			if (in_seg_q) begin
				burst.zeros = cap_count(trailer_q);
				burst.load = (burst.zeros != '0);
				in_seg_n = 1'b0;
				held_n = '0;
				counter_n = counter_q + SEG_BITS'(1);
			end
		end else if (!in_seg_q) begin
			if (v != '0) begin
				burst.zeros = cap_count(leader_q);
				burst.has_frame = 1'b1;
				burst.start = 1'b1;
				burst.load = 1'b1;
				in_seg_n = 1'b1;
				held_n = '0;
			end
		end else if (v == '0) begin
			if (held_inc >= split_cap) begin
				// run long enough: drop held blanks, emit trailer
				burst.zeros = cap_count(trailer_q);
				burst.load = (burst.zeros != '0);
				in_seg_n = 1'b0;
				held_n = '0;
				counter_n = counter_q + SEG_BITS'(1);
			end else begin
				held_n = held_inc;
			end
		end else begin
			burst.zeros = held_q;
			burst.has_frame = 1'b1;
			burst.load = 1'b1;
			held_n = '0;
		end
		if (!accept) begin
			burst.load = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_mode_q <= RST_FRAME_MODE;
			split_q <= RST_SPLIT_LENGTH;
			leader_q <= RST_LEADER_LENGTH;
			trailer_q <= RST_TRAILER_LENGTH;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_FRAME_MODE:     frame_mode_q <= cfg_data[1:0];
				REG_SPLIT_LENGTH:   split_q <= cfg_data;
				REG_LEADER_LENGTH:  leader_q <= cfg_data;
				REG_TRAILER_LENGTH: trailer_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_seg_q <= 1'b0;
			held_q <= '0;
			counter_q <= '0;
		end else if (accept) begin
			in_seg_q <= in_seg_n;
			held_q <= held_n;
			counter_q <= counter_n;
		end
	end

endmodule
`default_nettype wire

[design/tbrs_emit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbrs_emit
// Burst register and output register; counts out blanks, then the frame.
// ----------------------------------------------------------------------------
module tbrs_emit
	import tbrs_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire burst_t                burst,
	output logic                       free,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [FRAME_BITS-1:0]      out_frame,
	output logic [SEG_BITS-1:0]        out_seg,
	output logic                       out_start,
	output logic                       out_last
);

	logic                  valid_s1;
	logic [COUNT_BITS-1:0] zeros_s1;
	logic                  has_frame_s1;
	logic [FRAME_BITS-1:0] frame_s1;
	logic [SEG_BITS-1:0]   seg_s1;
	logic                  start_s1;

	logic move;
	logic last_now;

	assign move = valid_s1 && (!out_valid || out_ready);
	assign last_now = (zeros_s1 == '0) ||
		((zeros_s1 == COUNT_BITS'(1)) && !has_frame_s1);
	assign free = !valid_s1 || (move && last_now);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (burst.load) begin
			valid_s1 <= 1'b1;
		end else if (move && last_now) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (burst.load) begin
			zeros_s1 <= burst.zeros;
			has_frame_s1 <= burst.has_frame;
			frame_s1 <= burst.frame;
			seg_s1 <= burst.seg;
			start_s1 <= burst.start;
		end else if (move) begin
			if (zeros_s1 != '0) begin
				zeros_s1 <= zeros_s1 - COUNT_BITS'(1);
			end
			start_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (move) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_frame <= (zeros_s1 != '0) ? '0 : frame_s1;
			out_seg <= seg_s1;
			out_start <= start_s1;
			out_last <= last_now;
		end
	end

`ifndef SYNTHESIS
	a_burst_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && (zeros_s1 == '0) |-> has_frame_s1)
		else $error("burst with no result left");
	a_burst_stays: assert property (@(posedge clk) disable iff (!arst_n)
		move && !last_now |=> valid_s1)
		else $error("burst dropped before its last result");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		burst.load |-> free)
		else $error("burst loaded over a busy one");
`endif

endmodule
`default_nettype wire

[design/tape_blank_run_splitter_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tape_blank_run_splitter_unit
// Splits a tape frame stream into segments framed by leader and trailer.
// ----------------------------------------------------------------------------
// Order: a request enters the burst register, each result the output register.
// Throughput: one result per cycle unless m_tready stalls; a request with n results
//   holds the input in the burst counter till done; one-result ones flow each cycle.
// Reset: arst_n clears segment state, counter and valids; registers take
//   their default values.
module tape_blank_run_splitter_unit
	import tbrs_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [REG_BITS-1:0] cfg_data,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [7:0]          s_tdata,  // [7:0] frame_value
	input  wire logic                s_tuser,  // [0] action
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [23:0]              m_tdata,  // [7:0] out_frame, [23:8] segment_number
	output logic                     m_tuser,  // [0] segment_start
	output logic                     m_tlast
);

	burst_t                burst;
	logic                  free;
	logic [FRAME_BITS-1:0] out_frame;
	logic [SEG_BITS-1:0]   out_seg;

	assign s_tready = free;

	tbrs_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.accept      (s_tvalid && free),
		.action      (s_tuser),
		.frame_value (s_tdata),
		.burst       (burst)
	);

	tbrs_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.burst     (burst),
		.free      (free),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_frame (out_frame),
		.out_seg   (out_seg),
		.out_start (m_tuser),
		.out_last  (m_tlast)
	);

	assign m_tdata = {out_seg, out_frame};

endmodule
`default_nettype wire
